@@ src/set_assoc_cache_lru_tags_unit_assert.svh @@
// Assertion macros for the LRU tag store.
`ifndef SET_ASSOC_CACHE_LRU_TAGS_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_UNIT_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define SACL_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check that cond holds in the cycle after trig.
`define SACL_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ src/sacl_pkg.sv @@
package sacl_pkg;

    // Default geometry
    localparam int P_LINE_BYTES = 64;
    localparam int P_WAYS       = 8;
    localparam int P_SETS       = 64;
    localparam int P_ADDR_BITS  = 32;

    // Fixed port widths
    localparam int ADDR_W  = 32;
    localparam int WAY_W   = 3;
    localparam int COUNT_W = 32;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // Floor of log2, used at elaboration only
    function automatic int f_floor_log2(input int v);
        int n;
        int x;
        n = 0;
        x = v;
        while (x > 1) begin
            x = x >> 1;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

@@ src/set_assoc_cache_lru_tags_unit.sv @@
// Tag store of a set-associative cache with exact per-set LRU replacement. Each word on the
// input channel is a byte address; each produces one result word with hit/miss, the way hit
// or filled, and saturating access, hit and miss counts. Valid bits and LRU ranks of a set
// live in one synchronous memory row, tags in a second; a set is read at the edge that takes
// an address, searched and updated in the lookup stage and written back at the edge that
// moves it on, with the last written row forwarded. The block sustains one address per
// cycle while the result side takes each word. A result word is registered in the output
// stage when its set is written back; while that word waits on the result side, the lookup
// stage holds and no new address is taken. After reset a clearing pass sweeps the valid/rank
// memory one set per cycle; no address is taken until it ends.
module set_assoc_cache_lru_tags_unit
    import sacl_pkg::*;
#(
    parameter int LINE_BYTES = P_LINE_BYTES,
    parameter int WAYS       = P_WAYS,
    parameter int SETS       = P_SETS,
    parameter int ADDR_BITS  = P_ADDR_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [ADDR_W-1:0]  i_address,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_hit,
    output logic [WAY_W-1:0]   o_way_used,
    output logic [COUNT_W-1:0] o_access_count,
    output logic [COUNT_W-1:0] o_hit_count,
    output logic [COUNT_W-1:0] o_miss_count
);

    `include "set_assoc_cache_lru_tags_unit_assert.svh"

    localparam int OFF_BITS  = f_floor_log2(LINE_BYTES);
    localparam int IDX_BITS  = f_floor_log2(SETS);
    localparam int EFF_BITS  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int TAG_RAW   = EFF_BITS - OFF_BITS - IDX_BITS;
    localparam int TAG_BITS  = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_BITS = WAY_BITS;

    localparam logic [ADDR_W-1:0]    ADDR_MASK = ADDR_W'((64'(1) << EFF_BITS) - 64'(1));
    localparam logic [ADDR_W-1:0]    SET_MASK  = ADDR_W'((64'(1) << IDX_BITS) - 64'(1));
    localparam logic [RANK_BITS-1:0] RANK_LAST = RANK_BITS'(WAYS - 1);
    localparam logic [RANK_BITS:0]   RANK_NONE = (RANK_BITS + 1)'(WAYS);
    localparam logic [SET_BITS-1:0]  SET_LAST  = SET_BITS'(SETS - 1);

    typedef logic [WAYS-1:0][RANK_BITS-1:0] t_rank_row;
    typedef logic [WAYS-1:0][TAG_BITS-1:0]  t_tag_row;
    typedef struct packed {
        logic [WAYS-1:0] valid;
        t_rank_row       rank;
    } t_lru_row;

    // Memories
    t_lru_row mem_lru [SETS];
    t_tag_row mem_tag [SETS];

    // Control state
    t_state              r_state;
    t_state              n_state;
    logic [SET_BITS-1:0] r_clr_idx;
    logic                clr_we;
    logic                run;

    // Lookup stage
    logic                r_s1_v;
    logic [SET_BITS-1:0] r_s1_set;
    logic [TAG_BITS-1:0] r_s1_tag;
    t_lru_row            r_rd_lru;
    t_tag_row            r_rd_tag;

    // Forwarding of the last written row
    logic                r_wb_v;
    logic [SET_BITS-1:0] r_wb_set;
    t_lru_row            r_wb_lru;
    t_tag_row            r_wb_tag;

    // Output register and counters
    logic                r_out_v;
    logic                r_hit;
    logic [WAY_W-1:0]    r_way;
    logic [COUNT_W-1:0]  r_acc;
    logic [COUNT_W-1:0]  r_hits;
    logic [COUNT_W-1:0]  r_miss;

    logic                in_acc;
    logic                s1_adv;
    logic [ADDR_W-1:0]   addr_m;
    logic [SET_BITS-1:0] in_set;
    logic [TAG_BITS-1:0] in_tag;
    logic [SET_BITS-1:0] rd_addr;

    logic                fwd;
    t_lru_row            cur_lru;
    t_tag_row            cur_tag;
    logic                hit;
    logic [WAY_BITS-1:0] hit_way;
    logic                any_free;
    logic [WAY_BITS-1:0] free_way;
    logic [WAY_BITS-1:0] victim_way;
    logic [WAY_BITS-1:0] way;
    logic [RANK_BITS:0]  old_rank;
    t_lru_row            new_lru;
    t_tag_row            new_tag;
    logic [COUNT_W-1:0]  n_acc;
    logic [COUNT_W-1:0]  n_hits;
    logic [COUNT_W-1:0]  n_miss;

    // Next state: leave the clearing pass after the last set
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr_idx == SET_LAST) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        clr_we = 1'b0;
        run    = 1'b0;
        unique case (r_state)
            ST_CLEAR: clr_we = 1'b1;
            ST_RUN:   run    = 1'b1;
            default:  clr_we = 1'b1;
        endcase
    end

    // Handshake
    assign s1_adv     = r_s1_v && (!r_out_v || i_out_ready);
    assign o_in_ready = run && (!r_s1_v || s1_adv);
    assign in_acc     = i_in_valid && o_in_ready;

    // Split the incoming address
    assign addr_m  = i_address & ADDR_MASK;
    assign in_set  = SET_BITS'((addr_m >> OFF_BITS) & SET_MASK);
    assign in_tag  = TAG_BITS'(addr_m >> (OFF_BITS + IDX_BITS));
    assign rd_addr = in_acc ? in_set : r_s1_set;

    // Memory access: write back the modified set, or clear during the sweep
    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            mem_lru[r_clr_idx] <= '0;
        end else if (s1_adv) begin
            mem_lru[r_s1_set] <= new_lru;
        end
        if (s1_adv) begin
            mem_tag[r_s1_set] <= new_tag;
        end
        r_rd_lru <= mem_lru[rd_addr];
        r_rd_tag <= mem_tag[rd_addr];
    end

    // Pick the row, from the memory or from the write of the last cycle
    assign fwd     = r_wb_v && (r_wb_set == r_s1_set);
    assign cur_lru = fwd ? r_wb_lru : r_rd_lru;
    assign cur_tag = fwd ? r_wb_tag : r_rd_tag;

    // Search the set: lowest matching way, lowest free way, oldest way
    always_comb begin
        hit        = 1'b0;
        hit_way    = '0;
        any_free   = 1'b0;
        free_way   = '0;
        victim_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (cur_lru.valid[w] && (cur_tag[w] == r_s1_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_BITS'(w);
            end
            if (!cur_lru.valid[w]) begin
                any_free = 1'b1;
                free_way = WAY_BITS'(w);
            end
            if (cur_lru.rank[w] == RANK_LAST) begin
                victim_way = WAY_BITS'(w);
            end
        end
    end

    assign way      = hit ? hit_way : (any_free ? free_way : victim_way);
    assign old_rank = cur_lru.valid[way] ? {1'b0, cur_lru.rank[way]} : RANK_NONE;

    // Age the ways younger than the touched one, make it most recent
    always_comb begin
        new_lru = cur_lru;
        new_tag = cur_tag;
        for (int i = 0; i < WAYS; i++) begin
            if ((WAY_BITS'(i) != way) && cur_lru.valid[i]
                    && ({1'b0, cur_lru.rank[i]} < old_rank)) begin
                new_lru.rank[i] = cur_lru.rank[i] + 1'b1;
            end
        end
        new_lru.rank[way]  = '0;
        new_lru.valid[way] = 1'b1;
        new_tag[way]       = r_s1_tag;
    end

    // Saturating counters
    assign n_acc  = (r_acc == '1) ? r_acc : r_acc + 1'b1;
    assign n_hits = (hit && (r_hits != '1)) ? r_hits + 1'b1 : r_hits;
    assign n_miss = (!hit && (r_miss != '1)) ? r_miss + 1'b1 : r_miss;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_s1_v    <= 1'b0;
            r_wb_v    <= 1'b0;
            r_out_v   <= 1'b0;
            r_acc     <= '0;
            r_hits    <= '0;
            r_miss    <= '0;
        end else begin
            r_state <= n_state;
            if (clr_we) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (in_acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            r_wb_v <= s1_adv;
            if (s1_adv) begin
                r_out_v <= 1'b1;
                r_acc   <= n_acc;
                r_hits  <= n_hits;
                r_miss  <= n_miss;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_set <= in_set;
            r_s1_tag <= in_tag;
        end
        if (s1_adv) begin
            r_wb_set <= r_s1_set;
            r_wb_lru <= new_lru;
            r_wb_tag <= new_tag;
            r_hit    <= hit;
            r_way    <= WAY_W'(way);
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_hit          = r_hit;
    assign o_way_used     = r_way;
    assign o_access_count = r_acc;
    assign o_hit_count    = r_hits;
    assign o_miss_count   = r_miss;

    // Checks
    `SACL_ASSERT_SAME(a_no_accept_in_clear, r_state == ST_CLEAR, !o_in_ready, "word taken during clearing pass")
    `SACL_ASSERT_NEXT(a_adv_loads_output, s1_adv, r_out_v, "lookup advanced without loading a result")
    `SACL_ASSERT_SAME(a_counts_add_up, r_acc != '1, ({1'b0, r_hits} + {1'b0, r_miss}) == {1'b0, r_acc}, "hits plus misses differ from accesses")
    `SACL_ASSERT_NEXT(a_clear_sweeps,
        i_rst_n && (r_state == ST_CLEAR) && (r_clr_idx != SET_LAST),
        r_clr_idx == $past(r_clr_idx) + 1'b1, "clearing pass skipped a set")

endmodule
